// ===== design/tclm_pkg.sv =====
// Shared types, codes and the torque curve for the torque/current map.
package tclm_pkg;

    localparam int ROM_STORED = 79;
    localparam int MAG_W      = 32;
    localparam int RES_W      = 34;

    localparam logic [RES_W-1:0] POS_LIMIT = 34'h0_7FFF_FFFF;
    localparam logic [RES_W-1:0] NEG_LIMIT = 34'h0_8000_0000;

    // torque in mNm at 0.5 A steps
    localparam logic [14:0] MILLI [ROM_STORED] = '{
            0,   568,  1135,  1703,  2270,  2838,  3405,  3973,  4540,  5108,
         5675,  6243,  6810,  7378,  7945,  8513,  9080,  9648, 10215, 10783,
        11350, 11918, 12485, 13053, 13620, 14179, 14730, 15272, 15805, 16330,
        16847, 17355, 17855, 18346, 18827, 19299, 19762, 20215, 20658, 21093,
        21518, 21933, 22338, 22733, 23118, 23493, 23858, 24213, 24558, 24893,
        25218, 25536, 25846, 26148, 26443, 26731, 27011, 27283, 27548, 27806,
        28056, 28298, 28533, 28761, 28981, 29193, 29398, 29596, 29786, 29968,
        30143, 30312, 30474, 30630, 30780, 30924, 31061, 31192, 31317
    };

    typedef enum logic {
        OP_I2T = 1'b0,
        OP_T2I = 1'b1
    } t_opcode;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef enum logic [1:0] {
        U_IDLE,
        U_LOAD,
        U_ITER
    } t_unit_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SEARCH,
        S_LOAD_LO,
        S_LOAD_HI,
        S_START,
        S_RUN,
        S_DONE
    } t_state;

endpackage

// ===== design/tclm_if.sv =====
// Valid/ready channel interfaces for the input and result transfers.
interface tclm_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface tclm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_out;
    logic        saturated;

    modport source (output valid, output value_out, output saturated, input ready);
    modport sink   (input valid, input value_out, input saturated, output ready);
endinterface

// ===== design/tclm_rom.sv =====
// Constant torque curve table, scaled to the fixed-point format at elaboration.
module tclm_rom import tclm_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 7
) (
    input  logic [IDX_W-1:0]       i_idx,
    output logic [FRAC_BITS+4:0]   o_data
);

    localparam int ROM_W = FRAC_BITS + 5;
    localparam int DEPTH = 2 ** IDX_W;

    logic [ROM_W-1:0] rom_tab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        localparam int SRC = (g < ROM_STORED) ? g : ROM_STORED - 1;
        assign rom_tab[g] =
            ROM_W'(((64'(MILLI[SRC]) << FRAC_BITS) + 64'd500) / 64'd1000);
    end

    assign o_data = rom_tab[i_idx];

endmodule

// ===== design/tclm_serial_unit.sv =====
// Shared serial unit: shift-add multiply or restoring divide, one bit per cycle.
module tclm_serial_unit import tclm_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 21
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_unit_ctl                 i_ctl,
    input  logic [FRAC_BITS-1:0]      i_x,
    input  logic [DW-1:0]             i_d,
    input  logic [DW-1:0]             i_num,
    output logic                      o_done,
    output logic [FRAC_BITS+DW:0]     o_prod,
    output logic [FRAC_BITS-1:0]      o_quot
);

    localparam int ACC_W = FRAC_BITS + DW + 1;
    localparam int CW    = $clog2(FRAC_BITS);

    t_unit_state          r_state, n_state;
    t_unit_op             r_op, n_op;
    logic [FRAC_BITS-1:0] r_x, n_x;
    logic [DW-1:0]        r_y, n_y;
    logic [DW:0]          r_dv, n_dv;
    logic [DW-1:0]        r_num, n_num;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_done, n_done;

    logic [ACC_W-1:0]     add_a, add_b, sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_dv  <= n_dv;
        r_num <= n_num;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

    // operand select for the single adder
    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (r_state)
            U_LOAD: begin
                if (r_op == UOP_DIV) begin
                    add_a = ACC_W'(r_num);
                    add_b = ACC_W'(r_y >> FRAC_BITS);
                end
            end
            U_ITER: begin
                if (r_op == UOP_MUL) begin
                    add_a = r_acc << 1;
                    add_b = r_x[FRAC_BITS-1] ? ACC_W'(r_y) : '0;
                end else begin
                    add_a = {r_acc[ACC_W-2:0], r_x[FRAC_BITS-1]};
                    add_b = ~ACC_W'(r_dv) + ACC_W'(1);
                end
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign sum = add_a + add_b;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_x     = r_x;
        n_y     = r_y;
        n_dv    = r_dv;
        n_num   = r_num;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            U_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_ctl.op;
                    n_y     = i_d;
                    n_dv    = {i_d, 1'b0};
                    n_num   = i_num;
                    // divide: low dividend bits are the low divisor bits (rounding term)
                    n_x     = (i_ctl.op == UOP_DIV) ? i_d[FRAC_BITS-1:0] : i_x;
                    n_state = U_LOAD;
                end
            end
            U_LOAD: begin
                n_acc   = sum;
                n_cnt   = '0;
                n_state = U_ITER;
            end
            U_ITER: begin
                if (r_op == UOP_MUL) begin
                    n_acc = sum;
                    n_x   = r_x << 1;
                end else begin
                    n_acc = sum[ACC_W-1] ? add_a : sum;
                    n_x   = {r_x[FRAC_BITS-2:0], ~sum[ACC_W-1]};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(FRAC_BITS - 1)) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_quot = r_x;

endmodule

// ===== design/torque_current_lut_map_top.sv =====
// Top level: sequencer, table search and result register of the torque/current map.
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------
//  i_in     | in  | opcode, value_in (Q16.16)       | valid/ready
//  o_out    | out | value_out (Q16.16), saturated   | valid/ready
//
//  One item at a time; i_in.ready is high only while the sequencer is idle.
//  Current to torque: table lookup of the segment, then the serial multiply.
//  Torque to current: binary search of the table, then the serial divide.
//  Extrapolated items bypass the table and the serial unit.
//  A finished result waits in the output register; a stalled o_out holds the next item.
//  Synchronous active-low reset returns the sequencer to idle and empties the output.
module torque_current_lut_map_top import tclm_pkg::*; #(
    parameter int TABLE_ENTRIES = 79,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tclm_in_if.sink     i_in,
    tclm_out_if.source  o_out
);

    localparam int ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                             ((TABLE_ENTRIES > ROM_STORED) ? ROM_STORED : TABLE_ENTRIES);
    localparam int LAST    = ENTRIES - 1;
    localparam int IW      = $clog2(LAST + 1);
    localparam int LW      = IW + 2;
    localparam int ROM_W   = FRACTION_BITS + 5;
    localparam int ACC_W   = FRACTION_BITS + ROM_W + 1;

    localparam logic [MAG_W-1:0] LIM    = MAG_W'(LAST) << (FRACTION_BITS - 1);
    localparam logic [MAG_W-1:0] LIM_M2 = LIM - MAG_W'(2);
    localparam logic [ROM_W-1:0] TMAX   =
        ROM_W'(((64'(MILLI[LAST]) << FRACTION_BITS) + 64'd500) / 64'd1000);
    localparam logic [ACC_W-1:0] HALF   = ACC_W'(1) << (FRACTION_BITS - 1);

    t_state                  r_state, n_state;
    t_opcode                 r_op, n_op;
    logic                    r_neg, n_neg;
    logic [MAG_W-1:0]        r_mag, n_mag;
    logic signed [LW-1:0]    r_left, n_left;
    logic signed [LW-1:0]    r_right, n_right;
    logic [IW-1:0]           r_idx, n_idx;
    logic [ROM_W-1:0]        r_lo, n_lo;
    logic [ROM_W-1:0]        r_hi, n_hi;
    logic [RES_W-1:0]        r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    logic [31:0]             r_out_value, n_out_value;
    logic                    r_out_sat, n_out_sat;

    logic [IW-1:0]           rom_idx;
    logic [ROM_W-1:0]        rom_data;
    logic signed [LW:0]      mid_sum;
    logic signed [LW-1:0]    mid;
    logic [ROM_W-1:0]        seg_d;
    logic [RES_W-1:0]        fwd_ext, inv_ext, fwd_interp, inv_interp;
    logic [RES_W-1:0]        clip;
    t_unit_ctl               unit_ctl;
    logic                    u_done;
    logic [ACC_W-1:0]        u_prod;
    logic [FRACTION_BITS-1:0] u_quot;

    tclm_rom #(
        .FRAC_BITS (FRACTION_BITS),
        .IDX_W     (IW)
    ) u_rom (
        .i_idx  (rom_idx),
        .o_data (rom_data)
    );

    tclm_serial_unit #(
        .FRAC_BITS (FRACTION_BITS),
        .DW        (ROM_W)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (unit_ctl),
        .i_x     ({r_mag[FRACTION_BITS-2:0], 1'b0}),
        .i_d     (seg_d),
        .i_num   (ROM_W'(r_mag - MAG_W'(r_lo))),
        .o_done  (u_done),
        .o_prod  (u_prod),
        .o_quot  (u_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_left      <= n_left;
        r_right     <= n_right;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
    end

    assign mid_sum    = (LW + 1)'(r_left) + (LW + 1)'(r_right);
    assign mid        = LW'(mid_sum >>> 1);
    assign seg_d      = (r_hi > r_lo) ? (r_hi - r_lo) : '0;
    assign fwd_ext    = RES_W'(TMAX) + ((RES_W'(r_mag) - RES_W'(LIM_M2)) >> 2);
    assign inv_ext    = RES_W'(LIM) + ((RES_W'(r_mag) - RES_W'(TMAX)) << 2);
    assign fwd_interp = RES_W'(r_lo) + RES_W'((u_prod + HALF) >> FRACTION_BITS);
    assign inv_interp = (RES_W'(r_idx) << (FRACTION_BITS - 1)) + RES_W'(u_quot);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_left      = r_left;
        n_right     = r_right;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        rom_idx     = r_idx;
        unit_ctl    = '{start: 1'b0, op: UOP_MUL};
        clip        = r_res;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = t_opcode'(i_in.opcode);
                    n_neg   = i_in.value_in[31];
                    n_mag   = i_in.value_in[31] ? (~i_in.value_in + 32'd1) : i_in.value_in;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (r_op == OP_I2T) begin
                    if (r_mag < LIM) begin
                        n_idx   = r_mag[FRACTION_BITS-1 +: IW];
                        n_state = S_LOAD_LO;
                    end else begin
                        n_res   = fwd_ext;
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_mag < MAG_W'(TMAX)) begin
                        n_left  = '0;
                        n_right = LW'(LAST);
                        n_state = S_SEARCH;
                    end else begin
                        n_res   = inv_ext;
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                rom_idx = mid[IW-1:0];
                if (r_left <= r_right) begin
                    if (MAG_W'(rom_data) < r_mag) begin
                        n_left = mid + LW'(1);
                    end else begin
                        n_right = mid - LW'(1);
                    end
                end else if (r_right[LW-1]) begin
                    // zero torque: no segment below
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_right[IW-1:0];
                    n_state = S_LOAD_LO;
                end
            end
            S_LOAD_LO: begin
                rom_idx = r_idx;
                n_lo    = rom_data;
                n_state = S_LOAD_HI;
            end
            S_LOAD_HI: begin
                rom_idx = r_idx + IW'(1);
                n_hi    = rom_data;
                n_state = S_START;
            end
            S_START: begin
                if (r_op == OP_T2I && seg_d == '0) begin
                    n_res   = RES_W'(r_idx) << (FRACTION_BITS - 1);
                    n_state = S_DONE;
                end else begin
                    unit_ctl.start = 1'b1;
                    unit_ctl.op    = (r_op == OP_T2I) ? UOP_DIV : UOP_MUL;
                    n_state        = S_RUN;
                end
            end
            S_RUN: begin
                if (u_done) begin
                    n_res   = (r_op == OP_T2I) ? inv_interp : fwd_interp;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    if (r_neg) begin
                        n_out_sat   = (r_res > NEG_LIMIT);
                        clip        = n_out_sat ? NEG_LIMIT : r_res;
                        n_out_value = ~clip[31:0] + 32'd1;
                    end else begin
                        n_out_sat   = (r_res > POS_LIMIT);
                        clip        = n_out_sat ? POS_LIMIT : r_res;
                        n_out_value = clip[31:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.value_out = r_out_value;
    assign o_out.saturated = r_out_sat;

endmodule

// ===== design/tclm_checker.sv =====
// Port-level checks for the torque/current map, bound to the top level.
module tclm_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_sat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_sat))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new transfer taken while an item is in work");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |->
            (i_out_value == 32'h7FFF_FFFF) || (i_out_value == 32'h8000_0000))
        else $error("saturated result not at a range limit");

endmodule

bind torque_current_lut_map_top tclm_port_checker u_tclm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value_out),
    .i_out_sat   (o_out.saturated)
);

// ===== tb/sv/tclm_checker.sv =====
// Checker for the torque/current map: predicts each input transfer and checks result transfers.
`timescale 1ns / 100ps

module tclm_checker import tclm_pkg::*; #(
    parameter int TABLE_ENTRIES = 79,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tclm_in_if   in_ch,
    tclm_out_if  out_ch,
    output int   o_errors,
    output int   o_outstanding
);

    typedef struct packed {
        logic [31:0] value_out;
        logic        saturated;
    } t_mapped;

    localparam int USED_ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                                  (TABLE_ENTRIES > ROM_STORED) ? ROM_STORED : TABLE_ENTRIES;
    localparam int          LAST_KNOT = USED_ENTRIES - 1;
    localparam logic [63:0] HALF_LSB  = 64'd1 << (FRACTION_BITS - 1);
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRACTION_BITS) - 64'd1;
    localparam logic [63:0] LIN_LIMIT = 64'(LAST_KNOT) << (FRACTION_BITS - 1);
    localparam logic [63:0] WRAP      = 64'h1_0000_0000;

    t_mapped expected_q[$];
    int      mismatches = 0;

    // torque at knot k (0.5 A steps), fixed point
    function automatic logic [63:0] knot_torque(int k);
        int          j;
        logic [63:0] milli;
        j = k;
        if (j < 0) j = 0;
        if (j > ROM_STORED - 1) j = ROM_STORED - 1;
        milli = 64'(MILLI[j]);
        return ((milli << FRACTION_BITS) + 64'd500) / 64'd1000;
    endfunction

    function automatic logic [63:0] torque_of_current(logic [63:0] amps);
        logic [63:0] twice, w, lo, hi, d;
        int          idx;
        if (amps < LIN_LIMIT) begin
            twice = amps << 1;
            idx   = int'(twice >> FRACTION_BITS);
            w     = twice & FRAC_MASK;
            lo    = knot_torque(idx);
            hi    = knot_torque(idx + 1);
            d     = (hi > lo) ? hi - lo : 64'd0;
            return lo + ((w * d + HALF_LSB) >> FRACTION_BITS);
        end
        return knot_torque(LAST_KNOT) + ((amps - LIN_LIMIT + 64'd2) >> 2);
    endfunction

    function automatic logic [63:0] current_of_torque(logic [63:0] nm);
        int          left, right, mid;
        logic [63:0] lo, hi, d, tmax, base;
        tmax = knot_torque(LAST_KNOT);
        if (nm >= tmax) return LIN_LIMIT + ((nm - tmax) << 2);
        left  = 0;
        right = LAST_KNOT;
        while (left <= right) begin
            mid = (left + right) >> 1;
            if (knot_torque(mid) < nm) left = mid + 1;
            else right = mid - 1;
        end
        // zero torque: no segment below
        if (right < 0) return 64'd0;
        lo   = knot_torque(right);
        hi   = knot_torque(right + 1);
        d    = (hi > lo) ? hi - lo : 64'd0;
        base = 64'(right) << (FRACTION_BITS - 1);
        if (d == 64'd0) return base;
        return base + (((nm - lo) << FRACTION_BITS) + d) / (64'd2 * d);
    endfunction

    function automatic t_mapped map_item(t_opcode op, logic [31:0] raw);
        t_mapped     r;
        logic        neg;
        logic [63:0] mag, m;
        neg = raw[31];
        mag = neg ? WRAP - 64'(raw) : 64'(raw);
        m   = (op == OP_T2I) ? current_of_torque(mag) : torque_of_current(mag);
        r.saturated = 1'b0;
        if (neg) begin
            if (m > 64'(NEG_LIMIT)) begin
                m = 64'(NEG_LIMIT);
                r.saturated = 1'b1;
            end
            r.value_out = 32'(WRAP - m);
        end else begin
            if (m > 64'(POS_LIMIT)) begin
                m = 64'(POS_LIMIT);
                r.saturated = 1'b1;
            end
            r.value_out = 32'(m);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_mapped want;
        if (!i_rst_n) begin
            expected_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no item pending: value_out %h saturated %b",
                           out_ch.value_out, out_ch.saturated);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.value_out !== want.value_out) begin
                        $error("value_out mismatch: expected %h, actual %h",
                               want.value_out, out_ch.value_out);
                        mismatches++;
                    end
                    if (out_ch.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %b, actual %b",
                               want.saturated, out_ch.saturated);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(map_item(t_opcode'(in_ch.opcode), in_ch.value_in));
        end
        o_errors      <= mismatches;
        o_outstanding <= expected_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the torque/current map: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_top import tclm_pkg::*;;

    localparam int          STALL_CYCLES = 300;
    localparam int          ITEMS_PHASE  = 220;
    localparam int unsigned I2T_SPAN     = 32'h0026_FFFF;
    localparam int unsigned T2I_SPAN     = 32'h001F_5127;
    localparam int unsigned T2I_SAT_EDGE = 32'h2014_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int error_count;
    int pending_count;
    int send_idle_pct = 25;
    int recv_idle_pct = 50;
    bit stall_req = 1'b0;

    tclm_in_if  in_ch();
    tclm_out_if out_ch();

    torque_current_lut_map_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tclm_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_errors      (error_count),
        .o_outstanding (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random back-pressure, long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall_req) begin
                out_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                stall_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input t_opcode op, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= op;
        in_ch.value_in <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(t_opcode op);
        int unsigned sel;
        logic [63:0] knot;
        logic [31:0] mag;
        sel = $urandom_range(99);
        if (sel < 50) begin
            mag = (op == OP_I2T) ? $urandom_range(I2T_SPAN) : $urandom_range(T2I_SPAN);
        end else if (sel < 60) begin
            // near a knot of the curve
            knot = ((64'(MILLI[$urandom_range(ROM_STORED - 1)]) << 16) + 64'd500) / 64'd1000;
            mag  = 32'(knot) + $urandom_range(2) - 1;
        end else if (sel < 72) begin
            mag = I2T_SPAN + $urandom_range(32'h0100_0000);
        end else if (sel < 82) begin
            mag = T2I_SAT_EDGE + $urandom_range(32'h0003_0000);
        end else begin
            return $urandom;
        end
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic run_random(input int count);
        t_opcode op;
        for (int n = 0; n < count; n++) begin
            op = $urandom_range(1) ? OP_T2I : OP_I2T;
            if (n == 60) stall_req = 1'b1;
            if (n == 150) drain();
            send_item(op, pick_value(op));
        end
    endtask

    initial begin
        logic [32:0] directed [23] = '{
            {OP_I2T, 32'h0000_0000}, {OP_I2T, 32'h0000_0001}, {OP_I2T, 32'h0000_8000},
            {OP_I2T, 32'h0001_0000}, {OP_I2T, 32'h0026_FFFF}, {OP_I2T, 32'h0027_0000},
            {OP_I2T, 32'h7FFF_FFFF}, {OP_I2T, 32'h8000_0000}, {OP_I2T, 32'hFFFF_FFFF},
            {OP_I2T, 32'hFFFF_8000},
            {OP_T2I, 32'h0000_0000}, {OP_T2I, 32'h0000_0001}, {OP_T2I, 32'h0000_9168},
            {OP_T2I, 32'h0000_9169}, {OP_T2I, 32'h001F_5126}, {OP_T2I, 32'h001F_5127},
            {OP_T2I, 32'h001F_5128}, {OP_T2I, 32'h7FFF_FFFF}, {OP_T2I, 32'h8000_0000},
            {OP_T2I, 32'hFFFF_FFFF}, {OP_T2I, 32'h2015_9126}, {OP_T2I, 32'h2015_9127},
            {OP_T2I, 32'hDFEA_6ED9}
        };
        in_ch.valid    <= 1'b0;
        in_ch.opcode   <= OP_I2T;
        in_ch.value_in <= '0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        foreach (directed[k]) send_item(t_opcode'(directed[k][32]), directed[k][31:0]);
        run_random(ITEMS_PHASE);
        drain();

        send_idle_pct = 50;
        recv_idle_pct = 25;
        run_random(ITEMS_PHASE);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PHASE);
        drain();

        repeat (48) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tclm_pkg.sv
design/tclm_if.sv
design/tclm_rom.sv
design/tclm_serial_unit.sv
design/torque_current_lut_map_top.sv
design/tclm_checker.sv
tb/sv/tclm_checker.sv
tb/sv/tb_top.sv
